// ===== sv/monotone_stack_capped_prefix_sum_top_macros.svh =====
// Assertion macros shared by the monotone stack prefix-sum block.
`ifndef MONOTONE_STACK_CAPPED_PREFIX_SUM_TOP_MACROS_SVH
`define MONOTONE_STACK_CAPPED_PREFIX_SUM_TOP_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define MSPS_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define MSPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/msps_pkg.sv =====
// Shared constants and types of the monotone stack prefix-sum block.
package msps_pkg;

    localparam int MAX_LEN   = 1024;
    localparam int VAL_W     = 32;
    localparam int LEN_W     = $clog2(MAX_LEN + 1);
    localparam int POS_W     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int SUM_W     = VAL_W + LEN_W;
    localparam int OUT_W     = 42;
    localparam int CMP_W     = (SUM_W > OUT_W) ? SUM_W : OUT_W;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 48;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [POS_W-1:0] pos;
        logic [SUM_W-1:0] sum;
    } entry_t;

    typedef struct packed {
        logic push;
        logic pop;
    } stack_ctrl_t;

endpackage

// ===== sv/msps_cell.sv =====
// One stack cell: holds one entry, shifts down on push and up on pop.
module msps_cell
    import msps_pkg::*;
(
    input  logic        aclk,
    input  stack_ctrl_t ctrl,
    input  entry_t      from_up,
    input  entry_t      from_down,
    output entry_t      data
);

    entry_t data_reg;

    // hold the entry when neither push nor pop is asked for
    always_ff @(posedge aclk) begin
        if (ctrl.push) begin
            data_reg <= from_up;
        end else if (ctrl.pop) begin
            data_reg <= from_down;
        end
    end

    assign data = data_reg;

endmodule

// ===== sv/msps_stack.sv =====
// Shift stack built from a row of cells; cell 0 is the top of stack.
module msps_stack
    import msps_pkg::*;
(
    input  logic        aclk,
    input  stack_ctrl_t ctrl,
    input  entry_t      push_entry,
    output entry_t      top_entry
);

    entry_t cell_q [MAX_LEN];

    for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
        entry_t up_w;
        entry_t down_w;

        if (k == 0) begin : g_first
            assign up_w = push_entry;
        end else begin : g_mid_up
            assign up_w = cell_q[k-1];
        end

        // last cell pulls nothing in on pop; its contents are dead then
        if (k == MAX_LEN - 1) begin : g_last
            assign down_w = cell_q[k];
        end else begin : g_mid_down
            assign down_w = cell_q[k+1];
        end

        msps_cell u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .from_up   (up_w),
            .from_down (down_w),
            .data      (cell_q[k])
        );
    end

    assign top_entry = cell_q[0];

endmodule

// ===== sv/monotone_stack_capped_prefix_sum_top.sv =====
// Top level of the monotone stack capped prefix-sum block.
//
// Usage:
//   Input channel s_*: one sequence element per item. s_tdata[31:0] is the
//   element value; s_tuser[0] is start_req, which begins a new sequence with
//   this item (stack, position and overflow flag cleared first).
//   Result channel m_*: exactly one item per input item, in order.
//   m_tdata[41:0] is best_sum (upper bits zero), m_tuser[0] is overflow.
// Flow:
//   An item is accepted only in the idle state, so the next item waits until
//   this one is done. It first pops k stack entries; each pop is one shift of
//   the cell row. Every element is pushed once, so k averages below one. The
//   32 x 11 multiply is registered, the sum add follows, and its result is
//   registered with m_tvalid. An element past the length limit skips the
//   stack and the multiply.
// Reset: aresetn low clears the stack pointer, position, overflow flag and
//   the output valid flag; stack cells keep garbage that is never read.
// Stall: a waiting result sits in the output register while the next item
//   is taken and popped; the block holds in its final step until m_tready.
`include "monotone_stack_capped_prefix_sum_top_macros.svh"

module monotone_stack_capped_prefix_sum_top
    import msps_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [31:0] value
    input  logic [0:0]           s_tuser,   // [0] start_req
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [41:0] best_sum, [47:42] zero
    output logic [0:0]           m_tuser    // [0] overflow
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_POP  = 2'd1;
    localparam logic [1:0] ST_MUL  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    localparam logic [CMP_W-1:0] SUM_MAX = CMP_W'((64'd1 << OUT_W) - 64'd1);

    logic [1:0]       state_reg, state_next;
    logic [VAL_W-1:0] value_reg, value_next;
    logic [LEN_W-1:0] pos_reg, pos_next;
    logic [LEN_W-1:0] top_reg, top_next;
    logic             ovf_reg, ovf_next;
    logic             res_ovf_reg, res_ovf_next;
    logic [LEN_W-1:0] cnt_reg, cnt_next;
    logic [SUM_W-1:0] base_reg, base_next;
    logic [SUM_W-1:0] prod_reg, prod_next;

    logic             m_valid_reg, m_valid_next;
    logic [OUT_W-1:0] m_sum_reg, m_sum_next;
    logic             m_ovf_reg, m_ovf_next;

    logic             s_accept;
    logic             out_free;
    logic             start_w;
    logic [LEN_W-1:0] eff_pos, eff_top;
    logic             eff_ovf;
    logic             pop_hit;
    logic [SUM_W-1:0] sum_full;
    logic [OUT_W-1:0] sum_sat;

    stack_ctrl_t      stk_ctrl;
    entry_t           push_entry;
    entry_t           top_entry;

    msps_stack u_stack (
        .aclk       (aclk),
        .ctrl       (stk_ctrl),
        .push_entry (push_entry),
        .top_entry  (top_entry)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // start_req clears the sequence before this element is looked at
    assign start_w = s_tuser[0];
    assign eff_pos = start_w ? '0 : pos_reg;
    assign eff_top = start_w ? '0 : top_reg;
    assign eff_ovf = start_w ? 1'b0 : ovf_reg;

    // drop the top entry while it is not strictly smaller than the element
    assign pop_hit = (top_reg != '0) && (top_entry.value >= value_reg);

    assign prod_next = {{VAL_W{1'b0}}, cnt_reg} * {{LEN_W{1'b0}}, value_reg};
    assign sum_full  = base_reg + prod_reg;
    assign sum_sat   = (CMP_W'(sum_full) > SUM_MAX) ? SUM_MAX[OUT_W-1:0]
                                                     : OUT_W'(sum_full);

    assign push_entry.value = value_reg;
    assign push_entry.pos   = POS_W'(pos_reg);
    assign push_entry.sum   = sum_full;

    always_comb begin
        state_next   = state_reg;
        value_next   = value_reg;
        pos_next     = pos_reg;
        top_next     = top_reg;
        ovf_next     = ovf_reg;
        res_ovf_next = res_ovf_reg;
        cnt_next     = cnt_reg;
        base_next    = base_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_sum_next   = m_sum_reg;
        m_ovf_next   = m_ovf_reg;
        stk_ctrl     = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    value_next = s_tdata[VAL_W-1:0];
                    pos_next   = eff_pos;
                    top_next   = eff_top;
                    if (eff_ovf || (eff_pos >= LEN_W'(MAX_LEN))) begin
                        // sticky: answer zero and leave the stack alone
                        ovf_next     = 1'b1;
                        res_ovf_next = 1'b1;
                        state_next   = ST_FIN;
                    end else begin
                        ovf_next     = 1'b0;
                        res_ovf_next = 1'b0;
                        state_next   = ST_POP;
                    end
                end
            end
            ST_POP: begin
                if (pop_hit) begin
                    stk_ctrl.pop = 1'b1;
                    top_next     = top_reg - 1'b1;
                end else if (top_reg == '0) begin
                    cnt_next   = pos_reg + 1'b1;
                    base_next  = '0;
                    state_next = ST_MUL;
                end else begin
                    cnt_next   = pos_reg - LEN_W'(top_entry.pos);
                    base_next  = top_entry.sum;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                state_next = ST_FIN;
            end
            ST_FIN: begin
                // hold until the output register can take the result
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_ovf_next   = res_ovf_reg;
                    m_sum_next   = res_ovf_reg ? '0 : sum_sat;
                    if (!res_ovf_reg) begin
                        stk_ctrl.push = 1'b1;
                        top_next      = top_reg + 1'b1;
                        pos_next      = pos_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pos_reg     <= '0;
            top_reg     <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            top_reg     <= top_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg   <= value_next;
        res_ovf_reg <= res_ovf_next;
        cnt_reg     <= cnt_next;
        base_reg    <= base_next;
        prod_reg    <= prod_next;
        m_sum_reg   <= m_sum_next;
        m_ovf_reg   <= m_ovf_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'(m_sum_reg);
    assign m_tuser  = m_ovf_reg;

    `MSPS_ASSERT_IMPLY(a_top_le_pos, 1'b1, top_reg <= pos_reg,
        "stack holds more entries than elements seen")
    `MSPS_ASSERT_IMPLY(a_pop_nonempty, stk_ctrl.pop, top_reg != '0,
        "pop from an empty stack")
    `MSPS_ASSERT_IMPLY(a_ovf_zero, m_valid_reg && m_ovf_reg, m_sum_reg == '0,
        "overflowed result carries a nonzero sum")
    `MSPS_ASSERT_NEXT(a_accept_busy, s_accept, state_reg != ST_IDLE,
        "accepted item did not start work")

endmodule
